// ===== src/lcs_pkg.sv =====
// Shared types and constants for the linear contrast stretch block.
// Used by the controller, the datapath, the top level and the checker.
package lcs_pkg;

    localparam int PIXEL_BITS     = 16;
    localparam int OUT_MAX        = 255;
    localparam int LEVEL_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_MAP     = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_USER_RANGE_MODE = 3'd0,
        CFG_USER_MIN        = 3'd1,
        CFG_USER_MAX        = 3'd2,
        CFG_SKIP_ZERO       = 3'd3,
        CFG_ZERO_VALUE      = 3'd4
    } lcs_cfg_index_t;

    typedef struct packed {
        logic measure;
        logic capture;
        logic prep;
        logic step;
        logic emit;
    } lcs_cmd_t;

    typedef struct packed {
        logic map_item;
    } lcs_status_t;

endpackage

// ===== src/lcs_ctrl.sv =====
// Controller state machine for the linear contrast stretch block.
// Drives datapath commands from lcs_pkg::lcs_cmd_t and owns both handshakes.
module lcs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  lcs_pkg::lcs_status_t status,
    output lcs_pkg::lcs_cmd_t  cmd
);

    localparam int CNT_BITS = $clog2(lcs_pkg::LEVEL_BITS);
    localparam logic [CNT_BITS-1:0] STEP_LAST = CNT_BITS'(lcs_pkg::LEVEL_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd         = '0;
        cmd.measure = accept && !status.map_item;
        cmd.capture = accept && status.map_item;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                count_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/lcs_datapath.sv =====
// Datapath of the linear contrast stretch block: configuration registers,
// range tracking, scaling multiply and restoring divider. Uses lcs_pkg.
module lcs_datapath
#(
    parameter int PIXEL_BITS = lcs_pkg::PIXEL_BITS,
    parameter int OUT_MAX    = lcs_pkg::OUT_MAX
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lcs_pkg::lcs_cmd_t                    cmd,
    output lcs_pkg::lcs_status_t                 status,
    input  logic                                 cfg_write,
    input  logic [lcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [PIXEL_BITS-1:0]                cfg_data,
    input  logic                                 command,
    input  logic signed [PIXEL_BITS-1:0]         pixel,
    input  logic                                 last,
    output logic [lcs_pkg::LEVEL_BITS-1:0]       level,
    output logic                                 last_out
);

    localparam int L  = lcs_pkg::LEVEL_BITS;
    localparam int NW = PIXEL_BITS + L;
    localparam logic signed [PIXEL_BITS-1:0] TOP     = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] NEG_TOP =
        {1'b1, {(PIXEL_BITS-2){1'b0}}, 1'b1};

    logic                          mode_reg;
    logic                          mode_next;
    logic signed [PIXEL_BITS-1:0]  user_min_reg;
    logic signed [PIXEL_BITS-1:0]  user_min_next;
    logic signed [PIXEL_BITS-1:0]  user_max_reg;
    logic signed [PIXEL_BITS-1:0]  user_max_next;
    logic                          skip_reg;
    logic                          skip_next;
    logic signed [PIXEL_BITS-1:0]  zero_reg;
    logic signed [PIXEL_BITS-1:0]  zero_next;
    logic signed [PIXEL_BITS-1:0]  run_min_reg;
    logic signed [PIXEL_BITS-1:0]  run_min_next;
    logic signed [PIXEL_BITS-1:0]  run_max_reg;
    logic signed [PIXEL_BITS-1:0]  run_max_next;
    logic signed [PIXEL_BITS-1:0]  frame_min_reg;
    logic signed [PIXEL_BITS-1:0]  frame_min_next;
    logic signed [PIXEL_BITS-1:0]  frame_max_reg;
    logic signed [PIXEL_BITS-1:0]  frame_max_next;

    logic signed [PIXEL_BITS:0]    diff_reg;
    logic signed [PIXEL_BITS:0]    diff_next;
    logic signed [PIXEL_BITS:0]    span_reg;
    logic signed [PIXEL_BITS:0]    span_next;
    logic                          last_hold_reg;
    logic                          last_hold_next;
    logic                          sat_zero_reg;
    logic                          sat_zero_next;
    logic                          sat_max_reg;
    logic                          sat_max_next;
    logic [PIXEL_BITS-1:0]         divisor_reg;
    logic [PIXEL_BITS-1:0]         divisor_next;
    logic [PIXEL_BITS-1:0]         rem_reg;
    logic [PIXEL_BITS-1:0]         rem_next;
    logic [L-1:0]                  num_lo_reg;
    logic [L-1:0]                  num_lo_next;
    logic [L-1:0]                  quot_reg;
    logic [L-1:0]                  quot_next;
    logic [L-1:0]                  level_reg;
    logic [L-1:0]                  level_next;
    logic                          last_out_reg;
    logic                          last_out_next;

    logic                          skip_pixel;
    logic signed [PIXEL_BITS-1:0]  upd_min;
    logic signed [PIXEL_BITS-1:0]  upd_max;
    logic signed [PIXEL_BITS-1:0]  lo;
    logic signed [PIXEL_BITS-1:0]  hi;
    logic [NW-1:0]                 product;
    logic [PIXEL_BITS:0]           trial;
    logic                          trial_ge;

    assign status.map_item = (command == lcs_pkg::CMD_MAP);
    assign level           = level_reg;
    assign last_out        = last_out_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        user_min_next = user_min_reg;
        user_max_next = user_max_reg;
        skip_next     = skip_reg;
        zero_next     = zero_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lcs_pkg::CFG_USER_RANGE_MODE: mode_next     = cfg_data[0];
                lcs_pkg::CFG_USER_MIN:        user_min_next = cfg_data;
                lcs_pkg::CFG_USER_MAX:        user_max_next = cfg_data;
                lcs_pkg::CFG_SKIP_ZERO:       skip_next     = cfg_data[0];
                lcs_pkg::CFG_ZERO_VALUE:      zero_next     = cfg_data;
                default:                      mode_next     = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        skip_pixel     = skip_reg && (pixel == zero_reg);
        upd_min        = (!skip_pixel && (pixel < run_min_reg)) ? pixel : run_min_reg;
        upd_max        = (!skip_pixel && (pixel > run_max_reg)) ? pixel : run_max_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        frame_min_next = frame_min_reg;
        frame_max_next = frame_max_reg;
        if (cmd.measure)
        begin
            if (last)
            begin
                frame_min_next = upd_min;
                frame_max_next = upd_max;
                run_min_next   = TOP;
                run_max_next   = NEG_TOP;
            end
            else
            begin
                run_min_next = upd_min;
                run_max_next = upd_max;
            end
        end
    end

    always_comb
    begin
        lo       = mode_reg ? user_min_reg : frame_min_reg;
        hi       = mode_reg ? user_max_reg : frame_max_reg;
        product  = {{L{1'b0}}, diff_reg[PIXEL_BITS-1:0]} * NW'(OUT_MAX);
        trial    = {rem_reg, num_lo_reg[L-1]};
        trial_ge = (trial >= {1'b0, divisor_reg});

        diff_next      = diff_reg;
        span_next      = span_reg;
        last_hold_next = last_hold_reg;
        sat_zero_next  = sat_zero_reg;
        sat_max_next   = sat_max_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        num_lo_next    = num_lo_reg;
        quot_next      = quot_reg;
        level_next     = level_reg;
        last_out_next  = last_out_reg;

        if (cmd.capture)
        begin
            diff_next      = {pixel[PIXEL_BITS-1], pixel} - {lo[PIXEL_BITS-1], lo};
            span_next      = {hi[PIXEL_BITS-1], hi} - {lo[PIXEL_BITS-1], lo};
            last_hold_next = last;
        end
        if (cmd.prep)
        begin
            sat_zero_next = span_reg[PIXEL_BITS] || (span_reg == '0)
                            || diff_reg[PIXEL_BITS] || (diff_reg == '0);
            sat_max_next  = (diff_reg >= span_reg);
            divisor_next  = span_reg[PIXEL_BITS-1:0];
            rem_next      = product[NW-1:L];
            num_lo_next   = product[L-1:0];
            quot_next     = '0;
        end
        if (cmd.step)
        begin
            rem_next    = trial_ge ? PIXEL_BITS'(trial - {1'b0, divisor_reg})
                                   : trial[PIXEL_BITS-1:0];
            num_lo_next = {num_lo_reg[L-2:0], 1'b0};
            quot_next   = {quot_reg[L-2:0], trial_ge};
        end
        if (cmd.emit)
        begin
            if (sat_zero_reg)
            begin
                level_next = '0;
            end
            else if (sat_max_reg)
            begin
                level_next = L'(OUT_MAX);
            end
            else
            begin
                level_next = quot_reg;
            end
            last_out_next = last_hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            user_min_reg  <= '0;
            user_max_reg  <= PIXEL_BITS'(255);
            skip_reg      <= 1'b0;
            zero_reg      <= '0;
            run_min_reg   <= TOP;
            run_max_reg   <= NEG_TOP;
            frame_min_reg <= '0;
            frame_max_reg <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            user_min_reg  <= user_min_next;
            user_max_reg  <= user_max_next;
            skip_reg      <= skip_next;
            zero_reg      <= zero_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            frame_min_reg <= frame_min_next;
            frame_max_reg <= frame_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg      <= diff_next;
        span_reg      <= span_next;
        last_hold_reg <= last_hold_next;
        sat_zero_reg  <= sat_zero_next;
        sat_max_reg   <= sat_max_next;
        divisor_reg   <= divisor_next;
        rem_reg       <= rem_next;
        num_lo_reg    <= num_lo_next;
        quot_reg      <= quot_next;
        level_reg     <= level_next;
        last_out_reg  <= last_out_next;
    end

endmodule

// ===== src/linear_contrast_stretch.sv =====
// Top level of the linear contrast stretch block.
// Instantiates lcs_ctrl and lcs_datapath; types and defaults come from lcs_pkg.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  command, pixel, last
//   output   out_valid / out_stall level, last_out
//   config   cfg_write            cfg_index, cfg_data
//
// A measure transaction does not stall; the next item can follow at once.
// A map transaction stalls the input: it is captured, scaled by the multiply,
// divided by the one-bit-per-cycle restoring divider and then loaded into the
// output register before the next item is taken.
// Reset clears the control state and the configuration and range registers.
// A stalled output holds the controller only when a new map result is ready.
module linear_contrast_stretch
#(
    parameter int PIXEL_BITS = lcs_pkg::PIXEL_BITS,
    parameter int OUT_MAX    = lcs_pkg::OUT_MAX
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic signed [PIXEL_BITS-1:0]       pixel,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lcs_pkg::LEVEL_BITS-1:0]     level,
    output logic                               last_out,
    input  logic                               cfg_write,
    input  logic [lcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PIXEL_BITS-1:0]              cfg_data
);

    lcs_pkg::lcs_cmd_t    cmd;
    lcs_pkg::lcs_status_t status;

    lcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lcs_datapath
    #(
        .PIXEL_BITS (PIXEL_BITS),
        .OUT_MAX    (OUT_MAX)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command),
        .pixel     (pixel),
        .last      (last),
        .level     (level),
        .last_out  (last_out)
    );

endmodule

// ===== src/lcs_checker.sv =====
// Port-level checker for the linear contrast stretch block.
// Bound to linear_contrast_stretch; uses lcs_pkg for widths and codes.
module lcs_checker
#(
    parameter int OUT_MAX = lcs_pkg::OUT_MAX
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           command,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [lcs_pkg::LEVEL_BITS-1:0] level,
    input logic                           last_out
);

    logic map_accept;
    logic measure_accept;

    assign map_accept     = in_valid && !in_stall && (command == lcs_pkg::CMD_MAP);
    assign measure_accept = in_valid && !in_stall && (command == lcs_pkg::CMD_MEASURE);

    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        map_accept |=> in_stall)
        else $error("Input not stalled after a map transaction.");

    a_measure_free: assert property (@(posedge clk) disable iff (!rst_n)
        measure_accept |=> !in_stall)
        else $error("Input stalled after a measure transaction.");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("Result appeared without a map transaction in progress.");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level <= lcs_pkg::LEVEL_BITS'(OUT_MAX)))
        else $error("Output level above the maximum.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(level) && $stable(last_out)))
        else $error("Stalled output transaction changed.");

endmodule

bind linear_contrast_stretch lcs_checker
#(
    .OUT_MAX (OUT_MAX)
)
u_lcs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level),
    .last_out  (last_out)
);

// ===== test/testbench.sv =====
// Self-checking testbench for linear_contrast_stretch: directed and random pixel passes.
// It keeps its own copy of the range state and compares every output transaction.
// Depends on lcs_pkg and the linear_contrast_stretch top level in src.
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS  = 750;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANGE_TOP     = (1 << (lcs_pkg::PIXEL_BITS - 1)) - 1;
    localparam int PIXEL_LOW     = -(1 << (lcs_pkg::PIXEL_BITS - 1));

    typedef logic signed [lcs_pkg::PIXEL_BITS-1:0] sample_t;
    typedef logic [lcs_pkg::LEVEL_BITS-1:0] level_t;

    typedef struct {
        level_t level;
        logic   last_out;
    } level_item_t;

    logic                               clk;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    logic                               command   = lcs_pkg::CMD_MEASURE;
    sample_t                            pixel     = '0;
    logic                               last      = 1'b0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    level_t                             level;
    logic                               last_out;
    logic                               cfg_write = 1'b0;
    logic [lcs_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [lcs_pkg::PIXEL_BITS-1:0]     cfg_data  = '0;

    level_item_t pending_levels[$];
    int          mismatches = 0;
    int          items_sent = 0;

    logic    reg_mode     = 1'b0;
    sample_t reg_user_min = sample_t'(0);
    sample_t reg_user_max = sample_t'(255);
    logic    reg_skip     = 1'b0;
    sample_t reg_zero     = sample_t'(0);

    sample_t track_min = sample_t'(RANGE_TOP);
    sample_t track_max = sample_t'(-RANGE_TOP);
    sample_t range_min = sample_t'(0);
    sample_t range_max = sample_t'(0);

    int burst_left = 0;
    int win_lo     = PIXEL_LOW;
    int win_hi     = RANGE_TOP;
    int stall_run  = 0;
    logic stall_on = 1'b0;

    linear_contrast_stretch DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .pixel     (pixel),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .last_out  (last_out),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic level_t stretch_level(input sample_t p, input sample_t lo,
                                             input sample_t hi);
        longint offset;
        longint span;
        if (hi <= lo || p <= lo)
            return '0;
        if (p >= hi)
            return level_t'(lcs_pkg::OUT_MAX);
        offset = longint'(p) - longint'(lo);
        span   = longint'(hi) - longint'(lo);
        return level_t'((offset * lcs_pkg::OUT_MAX) / span);
    endfunction

    task automatic predict_pixel(input logic cmd, input sample_t p, input logic lst);
        level_item_t item;
        sample_t     lo;
        sample_t     hi;
        if (cmd == lcs_pkg::CMD_MEASURE)
        begin
            if (!(reg_skip && p == reg_zero))
            begin
                if (p > track_max)
                    track_max = p;
                if (p < track_min)
                    track_min = p;
            end
            if (lst)
            begin
                range_min = track_min;
                range_max = track_max;
                track_min = sample_t'(RANGE_TOP);
                track_max = sample_t'(-RANGE_TOP);
            end
        end
        else
        begin
            lo = reg_mode ? reg_user_min : range_min;
            hi = reg_mode ? reg_user_max : range_max;
            item.level    = stretch_level(p, lo, hi);
            item.last_out = lst;
            pending_levels.push_back(item);
        end
    endtask

    task automatic send_pixel(input logic cmd, input sample_t p, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        command  <= cmd;
        pixel    <= p;
        last     <= lst;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel(cmd, p, lst);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lcs_pkg::lcs_cfg_index_t idx,
                             input logic [lcs_pkg::PIXEL_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            lcs_pkg::CFG_USER_RANGE_MODE: reg_mode     = data[0];
            lcs_pkg::CFG_USER_MIN:        reg_user_min = sample_t'(data);
            lcs_pkg::CFG_USER_MAX:        reg_user_max = sample_t'(data);
            lcs_pkg::CFG_SKIP_ZERO:       reg_skip     = data[0];
            lcs_pkg::CFG_ZERO_VALUE:      reg_zero     = sample_t'(data);
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic sample_t any_sample();
        return sample_t'($urandom);
    endfunction

    function automatic sample_t window_sample();
        int pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       return sample_t'(PIXEL_LOW);
            1:       return sample_t'(RANGE_TOP);
            2, 3:    return reg_zero;
            4:       return any_sample();
            default: return sample_t'(win_lo + int'($urandom_range(0, win_hi - win_lo)));
        endcase
    endfunction

    always @(posedge clk)
    begin
        level_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_levels.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected, actual level %0d last_out %0b",
                         $time, level, last_out);
            end
            else
            begin
                want = pending_levels.pop_front();
                if (level !== want.level)
                begin
                    mismatches++;
                    $display("%0t: level expected %0d actual %0d", $time, want.level, level);
                end
                if (last_out !== want.last_out)
                begin
                    mismatches++;
                    $display("%0t: last_out expected %0b actual %0b",
                             $time, want.last_out, last_out);
                end
            end
        end
        if (stall_run == 0)
        begin
            stall_on = !stall_on;
            if (stall_on)
                stall_run = $urandom_range(1, 12);
            else
                stall_run = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 15);
        end
        stall_run--;
        out_stall <= stall_on;
    end

    task automatic test_reset_range();
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(100), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(PIXEL_LOW), 1'b1);
        settle();
        write_reg(lcs_pkg::CFG_USER_RANGE_MODE, 16'd1);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(0), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(128), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(255), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(256), 1'b1);
        settle();
    endtask

    task automatic test_measured_range();
        write_reg(lcs_pkg::CFG_USER_RANGE_MODE, 16'd0);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(PIXEL_LOW), 1'b0);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(RANGE_TOP), 1'b1);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(PIXEL_LOW), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(0), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(RANGE_TOP), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(-1), 1'b1);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(7), 1'b1);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(7), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(8), 1'b1);
        settle();
    endtask

    task automatic test_skip_background();
        write_reg(lcs_pkg::CFG_SKIP_ZERO, 16'd1);
        write_reg(lcs_pkg::CFG_ZERO_VALUE, 16'd5);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(5), 1'b0);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(5), 1'b1);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(5), 1'b1);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(0), 1'b0);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(5), 1'b0);
        send_pixel(lcs_pkg::CMD_MEASURE, sample_t'(10), 1'b1);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(5), 1'b1);
        settle();
        write_reg(lcs_pkg::CFG_SKIP_ZERO, 16'd0);
    endtask

    task automatic test_user_range();
        write_reg(lcs_pkg::CFG_USER_RANGE_MODE, 16'd1);
        write_reg(lcs_pkg::CFG_USER_MIN, 16'h8000);
        write_reg(lcs_pkg::CFG_USER_MAX, 16'h7FFF);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(PIXEL_LOW), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(RANGE_TOP), 1'b0);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(0), 1'b1);
        settle();
        write_reg(lcs_pkg::CFG_USER_MIN, 16'd10);
        write_reg(lcs_pkg::CFG_USER_MAX, 16'd10);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(10), 1'b1);
        settle();
        write_reg(lcs_pkg::CFG_USER_MIN, 16'd100);
        write_reg(lcs_pkg::CFG_USER_MAX, 16'hFF9C);
        send_pixel(lcs_pkg::CMD_MAP, sample_t'(0), 1'b1);
        settle();
    endtask

    task automatic pick_settings();
        int   kind;
        int   lo_v;
        int   hi_v;
        int   zero_v;
        logic mode_v;
        logic skip_v;
        kind = $urandom_range(0, 5);
        lo_v = int'($urandom_range(0, 65535)) + PIXEL_LOW;
        case (kind)
            0:
            begin
                lo_v = PIXEL_LOW;
                hi_v = RANGE_TOP;
            end
            1:       hi_v = (lo_v + 600 > RANGE_TOP) ? RANGE_TOP : lo_v + int'($urandom_range(1, 600));
            2:       hi_v = lo_v;
            3:       hi_v = int'($urandom_range(0, 65535)) + PIXEL_LOW;
            4:
            begin
                lo_v = PIXEL_LOW;
                hi_v = PIXEL_LOW + int'($urandom_range(1, 1000));
            end
            default:
            begin
                hi_v = RANGE_TOP;
                lo_v = RANGE_TOP - int'($urandom_range(1, 1000));
            end
        endcase
        mode_v = 1'($urandom_range(0, 1));
        skip_v = 1'($urandom_range(0, 1));
        if (mode_v)
        begin
            win_lo = ((lo_v < hi_v) ? lo_v : hi_v) - 50;
            win_hi = ((lo_v < hi_v) ? hi_v : lo_v) + 50;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            win_lo = PIXEL_LOW;
            win_hi = RANGE_TOP;
        end
        else
        begin
            win_lo = int'($urandom_range(0, 65535)) + PIXEL_LOW;
            win_hi = win_lo + int'($urandom_range(1, 400));
        end
        if (win_lo < PIXEL_LOW)
            win_lo = PIXEL_LOW;
        if (win_hi > RANGE_TOP)
            win_hi = RANGE_TOP;
        zero_v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) + PIXEL_LOW
                                             : win_lo + int'($urandom_range(0, win_hi - win_lo));
        write_reg(lcs_pkg::CFG_USER_MIN, 16'(lo_v));
        write_reg(lcs_pkg::CFG_USER_MAX, 16'(hi_v));
        write_reg(lcs_pkg::CFG_ZERO_VALUE, 16'(zero_v));
        write_reg(lcs_pkg::CFG_USER_RANGE_MODE, (16'($urandom) & 16'hFFFE) | 16'(mode_v));
        write_reg(lcs_pkg::CFG_SKIP_ZERO, (16'($urandom) & 16'hFFFE) | 16'(skip_v));
    endtask

    task automatic send_pass(input logic cmd, input int count, input logic close);
        for (int i = 0; i < count; i++)
            send_pixel(cmd, window_sample(), close && (i == count - 1));
    endtask

    task automatic run_sequence();
        int shape;
        shape = $urandom_range(0, 9);
        case (shape)
            7:
            begin
                repeat ($urandom_range(1, 12))
                    send_pixel(1'($urandom_range(0, 1)), any_sample(),
                               1'($urandom_range(0, 1)));
            end
            8:
            begin
                send_pass(lcs_pkg::CMD_MEASURE, $urandom_range(1, 6), 1'b0);
                send_pass(lcs_pkg::CMD_MAP, $urandom_range(1, 6), 1'b1);
            end
            9:       send_pass(lcs_pkg::CMD_MAP, $urandom_range(1, 8), 1'($urandom_range(0, 1)));
            default:
            begin
                send_pass(lcs_pkg::CMD_MEASURE, $urandom_range(1, 10), 1'b1);
                send_pass(lcs_pkg::CMD_MAP, $urandom_range(1, 10), 1'b1);
            end
        endcase
    endtask

    task automatic test_random_frames();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            settle();
            pick_settings();
            repeat ($urandom_range(3, 8)) run_sequence();
        end
        settle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_range();
        test_measured_range();
        test_skip_background();
        test_user_range();
        test_random_frames();
        settle();
        if (mismatches == 0 && pending_levels.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
